/* sv/frame_rate_jitter_monitor_assert.svh */
// Assertion macros shared by the frame rate and jitter monitor modules.
// No dependencies; included by the modules that carry assertions.
`ifndef FRAME_RATE_JITTER_MONITOR_ASSERT_SVH
`define FRAME_RATE_JITTER_MONITOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRJM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frjm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FRJM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frjm assertion failed");

`endif

/* sv/frjm_pkg.sv */
// Shared widths, codes, types and reset values of the frame rate monitor.
// No dependencies; used by scoped names by every file but the assertion header.
package frjm_pkg;

    localparam int TS_W       = 48;
    localparam int RATE_W     = 24;
    localparam int PER_W      = 32;
    localparam int TPS_W      = 32;
    localparam int LIM_W      = 16;
    localparam int FC_W       = 32;
    localparam int FCT_W      = FC_W + TPS_W;
    localparam int LT_W       = LIM_W + TPS_W;
    localparam int T5_W       = TPS_W + 3;
    localparam int PROD_W     = TS_W + RATE_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int HIT_W      = PROD_W + 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ITER_CNT_W = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_A        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_B        = 3'd4;

    // Configuration reset values
    localparam logic [TPS_W-1:0]  TPS_RESET    = 32'd10000000;
    localparam logic [LIM_W-1:0]  LIMIT_RESET  = 16'd3277;
    localparam logic [RATE_W-1:0] RATE_A_RESET = 24'd15360;
    localparam logic [RATE_W-1:0] RATE_B_RESET = 24'd7680;

    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    // Request and result codes
    localparam logic ACT_FRAME  = 1'b0;
    localparam logic ACT_READ   = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_LOG   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_LOAD,
        ST_ITER,
        ST_PICK,
        ST_TEST,
        ST_COMMIT,
        ST_READ,
        ST_RDEND
    } t_state;

    // One log entry as held in a cell
    typedef struct packed {
        logic              live;
        logic [TS_W-1:0]   stamp;
        logic [PER_W-1:0]  period;
        logic [RATE_W-1:0] rate;
    } t_entry;

    // Control broadcast to every cell of the log chain
    typedef struct packed {
        logic shift;
        logic expire;
    } t_cell_ctrl;

endpackage

/* sv/frjm_ifs.sv */
// Channel interfaces of the frame rate monitor: request, result and config.
// Depends on frjm_pkg for field widths.
interface frjm_in_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [frjm_pkg::TS_W-1:0] timestamp;

    modport source (output valid, action, timestamp, input ready);
    modport sink (input valid, action, timestamp, output ready);
endinterface

interface frjm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [frjm_pkg::RATE_W-1:0] measured_rate;
    logic [frjm_pkg::PER_W-1:0]  period_ticks;
    logic [frjm_pkg::RATE_W-1:0] chosen_rate;
    logic                        jitter_hit;
    logic                        entry_valid;
    logic                        last;

    modport source (output valid, kind, measured_rate, period_ticks, chosen_rate,
                    jitter_hit, entry_valid, last, input ready);
    modport sink (input valid, kind, measured_rate, period_ticks, chosen_rate,
                  jitter_hit, entry_valid, last, output ready);
endinterface

interface frjm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [frjm_pkg::CFG_IDX_W-1:0]  index;
    logic [frjm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/frame_rate_jitter_monitor.sv */
// Top level of the frame rate and frame jitter monitor.
// Depends on frjm_pkg, frjm_ifs, frjm_cell, frjm_iter and the assertion header.
//
// Frame requests (action 0) update the frame count, the measured Q16.8 rate and,
// with jitter checking on, test the period against the chosen nominal rate and
// shift hits into a LOG_DEPTH-cell log chain, via PREP, LOAD, ITER, PICK, TEST
// and COMMIT; ITER is the shared iterative unit (24 steps) that forms period
// times each nominal rate and the rate quotient one bit per step, and COMMIT
// waits for a free result register. A read request (action 1) rotates the log
// chain once around, holding while an entry cannot leave, and delivers the live
// entries oldest first, the newest flagged last, or one empty final result if
// none is live or jitter checking is off. The result register lets a new
// request be taken while the previous result waits. After reset the block is
// ready at once. Configuration writes are taken in any cycle and are meant for idle periods.
`include "frame_rate_jitter_monitor_assert.svh"

module frame_rate_jitter_monitor #(
    parameter int LOG_DEPTH = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frjm_in_if.sink     i_in,
    frjm_out_if.source  o_out,
    frjm_cfg_if.sink    i_cfg
);

    localparam int RD_CNT_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam logic [RD_CNT_W-1:0] RD_LAST = RD_CNT_W'(LOG_DEPTH - 1);

    // Configuration registers
    logic                          r_jit_en;
    logic [frjm_pkg::TPS_W-1:0]    r_tps;
    logic [frjm_pkg::LIM_W-1:0]    r_lim;
    logic [frjm_pkg::RATE_W-1:0]   r_rate_a;
    logic [frjm_pkg::RATE_W-1:0]   r_rate_b;

    // Monitor state
    logic [frjm_pkg::FC_W-1:0]     r_frame_count;
    logic [frjm_pkg::TS_W-1:0]     r_window_start;
    logic [frjm_pkg::TS_W-1:0]     r_prev_stamp;
    logic                          r_have_prev;
    logic [frjm_pkg::RATE_W-1:0]   r_rate_now;

    // Control
    frjm_pkg::t_state              r_state;
    frjm_pkg::t_state              n_state;
    logic [RD_CNT_W-1:0]           r_cnt;
    logic                          r_have_pend;
    logic                          r_ov;

    // Per-request working registers
    logic [frjm_pkg::TS_W-1:0]     r_t;
    logic [frjm_pkg::TS_W-1:0]     r_p;
    logic [frjm_pkg::TS_W-1:0]     r_el;
    logic [frjm_pkg::FCT_W-1:0]    r_fct;
    logic [frjm_pkg::LT_W-1:0]     r_lt;
    logic [frjm_pkg::T5_W-1:0]     r_t5;
    logic [frjm_pkg::FC_W-1:0]     r_fc_inc;
    logic                          r_near;
    logic                          r_check;
    logic                          r_close;
    logic                          r_pick;
    logic [frjm_pkg::RATE_W-1:0]   r_chosen;
    logic                          r_hit;
    logic [frjm_pkg::PER_W-1:0]    r_psat;
    logic [frjm_pkg::PER_W-1:0]    r_pend_period;
    logic [frjm_pkg::RATE_W-1:0]   r_pend_rate;

    // Result register
    logic                          r_o_kind;
    logic [frjm_pkg::RATE_W-1:0]   r_o_rate;
    logic [frjm_pkg::PER_W-1:0]    r_o_period;
    logic [frjm_pkg::RATE_W-1:0]   r_o_chosen;
    logic                          r_o_hit;
    logic                          r_o_evalid;
    logic                          r_o_last;

    // Sequencer outputs
    logic                          w_in_accept;
    logic                          w_out_free;
    logic                          w_iter_start;
    logic                          w_rotate;
    logic                          w_step;
    logic                          w_take;
    logic                          w_emit_frame;
    logic                          w_emit_pend;
    logic                          w_emit_end;
    frjm_pkg::t_cell_ctrl          w_cell_ctrl;

    // Arithmetic
    logic [frjm_pkg::TS_W-1:0]     w_p;
    logic [frjm_pkg::TS_W-1:0]     w_el;
    logic [frjm_pkg::FC_W-1:0]     w_fc_inc;
    logic [frjm_pkg::RATE_W-1:0]   w_da;
    logic [frjm_pkg::RATE_W-1:0]   w_db;
    logic                          w_iter_done;
    logic [frjm_pkg::PROD_W-1:0]   w_prod_a;
    logic [frjm_pkg::PROD_W-1:0]   w_prod_b;
    logic [frjm_pkg::RATE_W-1:0]   w_quot;
    logic                          w_sat;
    logic [frjm_pkg::SUM_W-1:0]    w_sum;
    logic [frjm_pkg::SUM_W-1:0]    w_t9;
    logic                          w_far;
    logic                          w_pick;
    logic [frjm_pkg::PROD_W-1:0]   w_ps;
    logic [frjm_pkg::PROD_W-1:0]   w_ref;
    logic [frjm_pkg::PROD_W-1:0]   w_d;
    logic                          w_hit;
    logic [frjm_pkg::RATE_W-1:0]   w_rate_new;

    // Log chain
    frjm_pkg::t_entry              w_ent [LOG_DEPTH];
    frjm_pkg::t_entry              w_tail;
    frjm_pkg::t_entry              w_new;
    logic [frjm_pkg::TS_W-1:0]     w_age_max;

    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_out_free  = !r_ov || o_out.ready;
    assign i_cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jit_en <= 1'b1;
            r_tps    <= frjm_pkg::TPS_RESET;
            r_lim    <= frjm_pkg::LIMIT_RESET;
            r_rate_a <= frjm_pkg::RATE_A_RESET;
            r_rate_b <= frjm_pkg::RATE_B_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                frjm_pkg::CFG_JITTER_ENABLE: r_jit_en <= i_cfg.data[0];
                frjm_pkg::CFG_TICKS_PER_SEC: r_tps    <= i_cfg.data;
                frjm_pkg::CFG_JITTER_LIMIT:  r_lim    <= i_cfg.data[frjm_pkg::LIM_W-1:0];
                frjm_pkg::CFG_RATE_A:        r_rate_a <= i_cfg.data[frjm_pkg::RATE_W-1:0];
                frjm_pkg::CFG_RATE_B:        r_rate_b <= i_cfg.data[frjm_pkg::RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frjm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and sequencer strobes
    always_comb begin
        n_state            = r_state;
        i_in.ready         = 1'b0;
        w_iter_start       = 1'b0;
        w_rotate           = 1'b0;
        w_step             = 1'b0;
        w_take             = 1'b0;
        w_emit_frame       = 1'b0;
        w_emit_pend        = 1'b0;
        w_emit_end         = 1'b0;
        w_cell_ctrl.shift  = 1'b0;
        w_cell_ctrl.expire = 1'b0;
        unique case (r_state)
            frjm_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.action == frjm_pkg::ACT_READ) begin
                        n_state = r_jit_en ? frjm_pkg::ST_READ : frjm_pkg::ST_RDEND;
                    end else begin
                        n_state = frjm_pkg::ST_PREP;
                    end
                end
            end
            frjm_pkg::ST_PREP: n_state = frjm_pkg::ST_LOAD;
            frjm_pkg::ST_LOAD: begin
                w_iter_start = 1'b1;
                n_state      = frjm_pkg::ST_ITER;
            end
            frjm_pkg::ST_ITER: begin
                if (w_iter_done) begin
                    n_state = frjm_pkg::ST_PICK;
                end
            end
            frjm_pkg::ST_PICK: n_state = frjm_pkg::ST_TEST;
            frjm_pkg::ST_TEST: n_state = frjm_pkg::ST_COMMIT;
            frjm_pkg::ST_COMMIT: begin
                if (w_out_free) begin
                    w_cell_ctrl.expire = r_check;
                    w_cell_ctrl.shift  = r_check && r_hit;
                    w_emit_frame       = 1'b1;
                    n_state            = frjm_pkg::ST_IDLE;
                end
            end
            frjm_pkg::ST_READ: begin
                // Hold the rotation while a pending entry cannot leave
                if (!(w_ent[0].live && r_have_pend && !w_out_free)) begin
                    w_cell_ctrl.shift = 1'b1;
                    w_rotate          = 1'b1;
                    w_step            = 1'b1;
                    if (w_ent[0].live) begin
                        w_take      = 1'b1;
                        w_emit_pend = r_have_pend;
                    end
                    if (r_cnt == RD_LAST) begin
                        n_state = frjm_pkg::ST_RDEND;
                    end
                end
            end
            frjm_pkg::ST_RDEND: begin
                if (w_out_free) begin
                    w_emit_end = 1'b1;
                    n_state    = frjm_pkg::ST_IDLE;
                end
            end
            default: n_state = frjm_pkg::ST_IDLE;
        endcase
    end

    // Read counter and pending entry flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_have_pend <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_cnt <= '0;
            end else if (w_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_take) begin
                r_have_pend <= 1'b1;
            end else if (w_emit_end) begin
                r_have_pend <= 1'b0;
            end
        end
    end

    // Hold the entry seen last until the next live one shows up
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pend_period <= w_ent[0].period;
            r_pend_rate   <= w_ent[0].rate;
        end
    end

    // Preparation terms from the accepted timestamp
    assign w_p      = (r_t >= r_prev_stamp) ? (r_t - r_prev_stamp) : '0;
    assign w_el     = (r_t >= r_window_start) ? (r_t - r_window_start) : '0;
    assign w_fc_inc = (r_frame_count == '1) ? r_frame_count : (r_frame_count + 1'b1);
    assign w_da     = (r_rate_a > r_rate_now) ? (r_rate_a - r_rate_now) : (r_rate_now - r_rate_a);
    assign w_db     = (r_rate_b > r_rate_now) ? (r_rate_b - r_rate_now) : (r_rate_now - r_rate_b);

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_t <= i_in.timestamp;
        end
        if (r_state == frjm_pkg::ST_PREP) begin
            r_p      <= w_p;
            r_el     <= w_el;
            r_fc_inc <= w_fc_inc;
            r_fct    <= frjm_pkg::FCT_W'(w_fc_inc) * frjm_pkg::FCT_W'(r_tps);
            r_lt     <= frjm_pkg::LT_W'(r_lim) * frjm_pkg::LT_W'(r_tps);
            r_t5     <= frjm_pkg::T5_W'({r_tps, 2'b00}) + frjm_pkg::T5_W'(r_tps);
            r_near   <= (w_da <= w_db);
            r_check  <= r_jit_en && r_have_prev;
            r_close  <= ({w_el, 1'b0} >= (frjm_pkg::TS_W + 1)'(r_tps));
        end
    end

    frjm_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_iter_start),
        .i_p      (r_p),
        .i_el     (r_el),
        .i_rate_a (r_rate_a),
        .i_rate_b (r_rate_b),
        .i_fct    (r_fct),
        .o_done   (w_iter_done),
        .o_prod_a (w_prod_a),
        .o_prod_b (w_prod_b),
        .o_quot   (w_quot),
        .o_sat    (w_sat)
    );

    // Nominal rate choice: nearer to old rate, else nearer to instant rate
    assign w_sum  = {1'b0, w_prod_a} + {1'b0, w_prod_b};
    assign w_t9   = frjm_pkg::SUM_W'({r_tps, 9'b0});
    assign w_far  = (r_rate_a < r_rate_b) ? (w_t9 <= w_sum) : (w_t9 >= w_sum);
    assign w_pick = r_near || (r_p == '0) || (r_rate_a == r_rate_b) || w_far;

    // Relative period error test
    assign w_ps  = r_pick ? w_prod_a : w_prod_b;
    assign w_ref = frjm_pkg::PROD_W'({r_tps, 8'b0});
    assign w_d   = (w_ps >= w_ref) ? (w_ps - w_ref) : (w_ref - w_ps);
    assign w_hit = ({w_d, 8'b0} >= frjm_pkg::HIT_W'(r_lt));

    always_ff @(posedge i_clk) begin
        if (r_state == frjm_pkg::ST_PICK) begin
            r_pick   <= w_pick;
            r_chosen <= w_pick ? r_rate_a : r_rate_b;
        end
        if (r_state == frjm_pkg::ST_TEST) begin
            r_hit  <= r_check && w_hit;
            r_psat <= (r_p[frjm_pkg::TS_W-1:frjm_pkg::PER_W] != '0) ? '1
                                                                  : r_p[frjm_pkg::PER_W-1:0];
        end
    end

    // New measured rate when the window closes
    always_comb begin
        if (!r_close) begin
            w_rate_new = r_rate_now;
        end else if (r_el == '0) begin
            w_rate_new = '0;
        end else if (w_sat) begin
            w_rate_new = frjm_pkg::RATE_MAX;
        end else begin
            w_rate_new = w_quot;
        end
    end

    // Commit monitor state on a frame result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count  <= '0;
            r_window_start <= '0;
            r_prev_stamp   <= '0;
            r_have_prev    <= 1'b0;
            r_rate_now     <= '0;
        end else if (w_emit_frame) begin
            r_frame_count <= r_close ? '0 : r_fc_inc;
            if (r_close) begin
                r_window_start <= r_t;
            end
            r_rate_now   <= w_rate_new;
            r_prev_stamp <= r_t;
            r_have_prev  <= 1'b1;
        end
    end

    // Log chain: cell i takes from cell i+1; the tail takes the new entry or cell 0
    assign w_age_max    = frjm_pkg::TS_W'(r_t5);
    assign w_new.live   = 1'b1;
    assign w_new.stamp  = r_t;
    assign w_new.period = r_psat;
    assign w_new.rate   = r_chosen;
    assign w_tail       = w_rotate ? w_ent[0] : w_new;

    for (genvar gi = 0; gi < LOG_DEPTH; gi++) begin : g_cell
        frjm_pkg::t_entry w_nb;
        if (gi == LOG_DEPTH - 1) begin : g_tail
            assign w_nb = w_tail;
        end else begin : g_mid
            assign w_nb = w_ent[gi+1];
        end
        frjm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_cell_ctrl),
            .i_now     (r_t),
            .i_age_max (w_age_max),
            .i_next    (w_nb),
            .o_ent     (w_ent[gi])
        );
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit_frame || w_emit_pend || w_emit_end) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        priority if (w_emit_frame) begin
            r_o_kind   <= frjm_pkg::KIND_FRAME;
            r_o_rate   <= w_rate_new;
            r_o_period <= r_check ? r_psat : '0;
            r_o_chosen <= r_check ? r_chosen : '0;
            r_o_hit    <= r_hit;
            r_o_evalid <= 1'b0;
            r_o_last   <= 1'b1;
        end else if (w_emit_pend) begin
            r_o_kind   <= frjm_pkg::KIND_LOG;
            r_o_rate   <= r_rate_now;
            r_o_period <= r_pend_period;
            r_o_chosen <= r_pend_rate;
            r_o_hit    <= 1'b0;
            r_o_evalid <= 1'b1;
            r_o_last   <= 1'b0;
        end else if (w_emit_end) begin
            r_o_kind   <= frjm_pkg::KIND_LOG;
            r_o_rate   <= r_rate_now;
            r_o_period <= r_have_pend ? r_pend_period : '0;
            r_o_chosen <= r_have_pend ? r_pend_rate : '0;
            r_o_hit    <= 1'b0;
            r_o_evalid <= r_have_pend;
            r_o_last   <= 1'b1;
        end else begin
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.kind          = r_o_kind;
    assign o_out.measured_rate = r_o_rate;
    assign o_out.period_ticks  = r_o_period;
    assign o_out.chosen_rate   = r_o_chosen;
    assign o_out.jitter_hit    = r_o_hit;
    assign o_out.entry_valid   = r_o_evalid;
    assign o_out.last          = r_o_last;

    `FRJM_ASSERT_SAME(a_done_in_iter, i_clk, i_rst_n, w_iter_done, r_state == frjm_pkg::ST_ITER)
    `FRJM_ASSERT_NEXT(a_frame_result, i_clk, i_rst_n, w_emit_frame, (r_ov && !o_out.kind && o_out.last && r_have_prev))
    `FRJM_ASSERT_NEXT(a_read_closes, i_clk, i_rst_n, w_emit_end, (r_ov && o_out.kind && o_out.last && !r_have_pend))
    `FRJM_ASSERT_SAME(a_pend_in_read, i_clk, i_rst_n, r_have_pend, (r_state == frjm_pkg::ST_READ || r_state == frjm_pkg::ST_RDEND))

endmodule

/* sv/frjm_cell.sv */
// One cell of the jitter log chain: holds an entry, ages it, passes it on.
// Depends on frjm_pkg for the entry and control types.
module frjm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  frjm_pkg::t_cell_ctrl      i_ctrl,
    input  logic [frjm_pkg::TS_W-1:0] i_now,
    input  logic [frjm_pkg::TS_W-1:0] i_age_max,
    input  frjm_pkg::t_entry          i_next,
    output frjm_pkg::t_entry          o_ent
);

    logic                        r_live;
    logic [frjm_pkg::TS_W-1:0]   r_stamp;
    logic [frjm_pkg::PER_W-1:0]  r_period;
    logic [frjm_pkg::RATE_W-1:0] r_rate;

    logic w_expired;
    logic w_live;

    // Age out entries older than the limit; a stamp in the future stays
    assign w_expired = r_live && (i_now >= r_stamp) && ((i_now - r_stamp) > i_age_max);
    assign w_live    = r_live && !(i_ctrl.expire && w_expired);

    assign o_ent.live   = w_live;
    assign o_ent.stamp  = r_stamp;
    assign o_ent.period = r_period;
    assign o_ent.rate   = r_rate;

    // Live bit: take the neighbor's on a shift, else drop on expiry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_live <= i_next.live;
        end else begin
            r_live <= w_live;
        end
    end

    // Payload follows the shift
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_stamp  <= i_next.stamp;
            r_period <= i_next.period;
            r_rate   <= i_next.rate;
        end
    end

endmodule

/* sv/frjm_iter.sv */
// Shared iterative unit: period times both nominal rates, and rate quotient.
// Depends on frjm_pkg and frame_rate_jitter_monitor_assert.svh.
`include "frame_rate_jitter_monitor_assert.svh"

module frjm_iter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [frjm_pkg::TS_W-1:0]   i_p,
    input  logic [frjm_pkg::TS_W-1:0]   i_el,
    input  logic [frjm_pkg::RATE_W-1:0] i_rate_a,
    input  logic [frjm_pkg::RATE_W-1:0] i_rate_b,
    input  logic [frjm_pkg::FCT_W-1:0]  i_fct,
    output logic                        o_done,
    output logic [frjm_pkg::PROD_W-1:0] o_prod_a,
    output logic [frjm_pkg::PROD_W-1:0] o_prod_b,
    output logic [frjm_pkg::RATE_W-1:0] o_quot,
    output logic                        o_sat
);

    localparam logic [frjm_pkg::ITER_CNT_W-1:0] ITER_FIRST =
        frjm_pkg::ITER_CNT_W'(frjm_pkg::RATE_W - 1);

    logic                            r_busy;
    logic                            r_done;
    logic [frjm_pkg::ITER_CNT_W-1:0] r_cnt;
    logic [frjm_pkg::TS_W-1:0]       r_p;
    logic [frjm_pkg::RATE_W-1:0]     r_ka;
    logic [frjm_pkg::RATE_W-1:0]     r_kb;
    logic [frjm_pkg::PROD_W-1:0]     r_acc_a;
    logic [frjm_pkg::PROD_W-1:0]     r_acc_b;
    logic [frjm_pkg::PROD_W-1:0]     r_rem;
    logic [frjm_pkg::PROD_W-1:0]     r_div;
    logic [frjm_pkg::RATE_W-1:0]     r_quot;
    logic                            r_sat;

    logic [frjm_pkg::PROD_W-1:0] n_acc_a;
    logic [frjm_pkg::PROD_W-1:0] n_acc_b;
    logic                        w_fit;

    // Multiply msb first: double and add the period where the rate bit is set
    assign n_acc_a = {r_acc_a[frjm_pkg::PROD_W-2:0], 1'b0}
                   + (r_ka[frjm_pkg::RATE_W-1] ? frjm_pkg::PROD_W'(r_p) : '0);
    assign n_acc_b = {r_acc_b[frjm_pkg::PROD_W-2:0], 1'b0}
                   + (r_kb[frjm_pkg::RATE_W-1] ? frjm_pkg::PROD_W'(r_p) : '0);

    // Restoring division, one quotient bit a step
    assign w_fit = (r_div <= r_rem);

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ITER_FIRST;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load on start, advance while busy
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p     <= i_p;
            r_ka    <= i_rate_a;
            r_kb    <= i_rate_b;
            r_acc_a <= '0;
            r_acc_b <= '0;
            r_rem   <= {i_fct, 8'b0};
            r_div   <= {1'b0, i_el, {(frjm_pkg::RATE_W - 1){1'b0}}};
            r_quot  <= '0;
            r_sat   <= ({i_fct, 8'b0} >= {i_el, {frjm_pkg::RATE_W{1'b0}}});
        end else if (r_busy) begin
            r_ka    <= {r_ka[frjm_pkg::RATE_W-2:0], 1'b0};
            r_kb    <= {r_kb[frjm_pkg::RATE_W-2:0], 1'b0};
            r_acc_a <= n_acc_a;
            r_acc_b <= n_acc_b;
            if (w_fit) begin
                r_rem <= r_rem - r_div;
            end
            r_quot <= {r_quot[frjm_pkg::RATE_W-2:0], w_fit};
            r_div  <= {1'b0, r_div[frjm_pkg::PROD_W-1:1]};
        end
    end

    assign o_done   = r_done;
    assign o_prod_a = r_acc_a;
    assign o_prod_b = r_acc_b;
    assign o_quot   = r_quot;
    assign o_sat    = r_sat;

    `FRJM_ASSERT_NEXT(a_iter_done_after_last, i_clk, i_rst_n, (r_busy && r_cnt == '0 && !i_start), o_done)
    `FRJM_ASSERT_SAME(a_iter_start_idle, i_clk, i_rst_n, i_start, !r_busy)

endmodule

/* test/tb_top.sv */
// Self-checking testbench of the frame rate and jitter monitor.
// Depends on frjm_pkg, frjm_ifs and frame_rate_jitter_monitor; a built-in
// predictor of rate, nominal-rate choice and jitter log checks every result.
module tb_top;

    typedef struct packed {
        logic                        kind;
        logic [frjm_pkg::RATE_W-1:0] rate;
        logic [frjm_pkg::PER_W-1:0]  period;
        logic [frjm_pkg::RATE_W-1:0] chosen;
        logic                        hit;
        logic                        valid;
        logic                        last;
    } t_result;

    localparam int DEPTH = 20;
    localparam int STALL_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    frjm_in_if  in_if();
    frjm_out_if out_if();
    frjm_cfg_if cfg_if();

    frame_rate_jitter_monitor #(.LOG_DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predictor copy of configuration and state
    logic                        en_q;
    logic [frjm_pkg::TPS_W-1:0]  tps_q;
    logic [frjm_pkg::LIM_W-1:0]  lim_q;
    logic [frjm_pkg::RATE_W-1:0] rate_a_q, rate_b_q;
    logic [frjm_pkg::FC_W-1:0]   frames_q;
    logic [frjm_pkg::TS_W-1:0]   win_start_q, prev_stamp_q;
    logic                        have_prev_q;
    logic [frjm_pkg::RATE_W-1:0] rate_now_q;
    logic                        log_live_q  [DEPTH];
    logic [frjm_pkg::TS_W-1:0]   log_stamp_q [DEPTH];
    logic [frjm_pkg::PER_W-1:0]  log_per_q   [DEPTH];
    logic [frjm_pkg::RATE_W-1:0] log_rate_q  [DEPTH];

    t_result expected_results[$];
    bit      quiet = 1'b0;
    bit      failed = 1'b0;
    int      stall_left = 0;
    int      quiet_cycles = 0;
    logic [frjm_pkg::TS_W-1:0] ts_now;

    // Clock
    always #4 i_clk = ~i_clk;

    // Compute the results of one accepted request and advance the state
    task automatic predict_request(input logic act, input logic [frjm_pkg::TS_W-1:0] ts);
        t_result       r;
        logic [127:0]  p, a, b, da, db, big_t, ps, ref_v, d, num, el;
        logic [frjm_pkg::PER_W-1:0]  psat;
        logic [frjm_pkg::RATE_W-1:0] chosen;
        logic          hit, pick_a;
        int            n;
        r = '0;
        big_t = 128'(tps_q);
        if (act == frjm_pkg::ACT_READ) begin
            n = 0;
            if (en_q) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (log_live_q[i]) begin
                        r = '{frjm_pkg::KIND_LOG, rate_now_q, log_per_q[i], log_rate_q[i],
                              1'b0, 1'b1, 1'b0};
                        expected_results.push_back(r);
                        n++;
                    end
                end
            end
            if (n == 0) begin
                r = '{frjm_pkg::KIND_LOG, rate_now_q, '0, '0, 1'b0, 1'b0, 1'b1};
                expected_results.push_back(r);
            end else begin
                expected_results[$].last = 1'b1;
            end
            return;
        end
        psat = '0;
        chosen = '0;
        hit = 1'b0;
        if (frames_q != '1) frames_q++;
        if (en_q && have_prev_q) begin
            p = (ts >= prev_stamp_q) ? 128'(ts - prev_stamp_q) : '0;
            a = 128'(rate_a_q);
            b = 128'(rate_b_q);
            da = (a > rate_now_q) ? a - rate_now_q : rate_now_q - a;
            db = (b > rate_now_q) ? b - rate_now_q : rate_now_q - b;
            pick_a = (da <= db);
            if (!pick_a) begin
                if (p == 0 || a == b) pick_a = 1'b1;
                else if (a < b) pick_a = (big_t * 512 <= (a + b) * p);
                else pick_a = (big_t * 512 >= (a + b) * p);
            end
            chosen = pick_a ? rate_a_q : rate_b_q;
            // Expire entries older than five seconds
            for (int i = 0; i < DEPTH; i++) begin
                if (log_live_q[i] && ts >= log_stamp_q[i] &&
                    128'(ts - log_stamp_q[i]) > big_t * 5)
                    log_live_q[i] = 1'b0;
            end
            ps = p * 128'(chosen);
            ref_v = big_t * 256;
            d = (ps >= ref_v) ? ps - ref_v : ref_v - ps;
            hit = ((d << 8) >= 128'(lim_q) * big_t);
            psat = (p > 128'(32'hFFFF_FFFF)) ? '1 : p[frjm_pkg::PER_W-1:0];
            if (hit) begin
                for (int i = 0; i + 1 < DEPTH; i++) begin
                    log_live_q[i]  = log_live_q[i+1];
                    log_stamp_q[i] = log_stamp_q[i+1];
                    log_per_q[i]   = log_per_q[i+1];
                    log_rate_q[i]  = log_rate_q[i+1];
                end
                log_live_q[DEPTH-1]  = 1'b1;
                log_stamp_q[DEPTH-1] = ts;
                log_per_q[DEPTH-1]   = psat;
                log_rate_q[DEPTH-1]  = chosen;
            end
        end
        // Close the rate window after half a second
        el = (ts >= win_start_q) ? 128'(ts - win_start_q) : '0;
        if (el * 2 >= big_t) begin
            if (el == 0) begin
                rate_now_q = '0;
            end else begin
                num = (128'(frames_q) * big_t) << 8;
                if (num >= (el << 24)) rate_now_q = frjm_pkg::RATE_MAX;
                else rate_now_q = frjm_pkg::RATE_W'(num / el);
            end
            frames_q = '0;
            win_start_q = ts;
        end
        prev_stamp_q = ts;
        have_prev_q = 1'b1;
        r = '{frjm_pkg::KIND_FRAME, rate_now_q, psat, chosen, hit, 1'b0, 1'b1};
        expected_results.push_back(r);
    endtask

    // Send one request, with an occasional gap before it
    task automatic send_request(input logic act, input logic [frjm_pkg::TS_W-1:0] ts);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.action = act;
        in_if.timestamp = ts;
        do @(posedge i_clk); while (!in_if.ready);
        predict_request(act, ts);
    endtask

    task automatic send_frame(input logic [frjm_pkg::TS_W-1:0] ts);
        send_request(frjm_pkg::ACT_FRAME, ts);
    endtask

    task automatic send_read();
        send_request(frjm_pkg::ACT_READ, frjm_pkg::TS_W'({$urandom, $urandom}));
    endtask

    // Drop valid and wait until every result has come, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [frjm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [frjm_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            frjm_pkg::CFG_JITTER_ENABLE: en_q = val[0];
            frjm_pkg::CFG_TICKS_PER_SEC: tps_q = val;
            frjm_pkg::CFG_JITTER_LIMIT:  lim_q = val[frjm_pkg::LIM_W-1:0];
            frjm_pkg::CFG_RATE_A:        rate_a_q = val[frjm_pkg::RATE_W-1:0];
            frjm_pkg::CFG_RATE_B:        rate_b_q = val[frjm_pkg::RATE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic write_all(input logic en, input logic [frjm_pkg::TPS_W-1:0] tps,
                             input logic [frjm_pkg::LIM_W-1:0] lim,
                             input logic [frjm_pkg::RATE_W-1:0] ra,
                             input logic [frjm_pkg::RATE_W-1:0] rb);
        write_reg(frjm_pkg::CFG_JITTER_ENABLE, 32'(en));
        write_reg(frjm_pkg::CFG_TICKS_PER_SEC, tps);
        write_reg(frjm_pkg::CFG_JITTER_LIMIT, 32'(lim));
        write_reg(frjm_pkg::CFG_RATE_A, 32'(ra));
        write_reg(frjm_pkg::CFG_RATE_B, 32'(rb));
    endtask

    // Frames at a nominal rate with jitter, some reads, gaps and noise
    task automatic frame_stream(input int count, input logic [frjm_pkg::RATE_W-1:0] rate);
        logic [63:0] per;
        int          jit, pick;
        per = (64'(tps_q) * 256) / ((rate == 0) ? 1 : rate);
        if (per == 0) per = 1;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_read();
            end else if (pick < 13) begin
                send_frame(frjm_pkg::TS_W'({$urandom, $urandom}));
            end else begin
                if (pick < 15) ts_now += frjm_pkg::TS_W'(64'(tps_q) * 6);
                jit = $urandom_range(0, 3) == 0 ? $urandom_range(0, 60) : $urandom_range(0, 4);
                ts_now += frjm_pkg::TS_W'(per + (per * jit) / 100 - (per * 2) / 100);
                send_frame(ts_now);
            end
        end
    endtask

    task automatic test_directed_edges();
        send_read();
        send_frame('0);
        send_frame('0);
        send_frame(48'd1_000_000);
        send_frame(48'd1_700_000);
        send_frame('1);
        send_frame(48'd5);
        send_read();
        wait_idle();
        write_all(1'b1, 32'hFFFF_FFFF, 16'hFFFF, frjm_pkg::RATE_MAX, 24'd1);
        send_frame(48'h7FFF_FFFF_FFFF);
        send_frame(48'h8000_0000_0000);
        send_frame(48'hFFFF_FFFF_FFFE);
        send_read();
        wait_idle();
        write_all(1'b1, 32'd1, 16'd0, 24'd1, 24'd1);
        send_frame(48'd10);
        send_frame(48'd10);
        send_frame(48'd11);
        send_frame(48'd30);
        send_read();
        wait_idle();
        write_all(1'b0, 32'd1000, 16'd3277, 24'd15360, 24'd7680);
        send_frame(48'd100);
        send_frame(48'd117);
        send_read();
        wait_idle();
    endtask

    task automatic test_log_expiry();
        write_all(1'b1, 32'd1000, 16'd655, 24'd15360, 24'd7680);
        ts_now = 48'd50_000;
        for (int i = 0; i < 24; i++) begin
            ts_now += frjm_pkg::TS_W'($urandom_range(1, 40));
            send_frame(ts_now);
        end
        send_read();
        ts_now += 48'd5_500;
        send_frame(ts_now);
        send_read();
        wait_idle();
    endtask

    task automatic test_random_phases(input int phases);
        logic [frjm_pkg::TPS_W-1:0]  tps;
        logic [frjm_pkg::RATE_W-1:0] ra, rb;
        for (int ph = 0; ph < phases; ph++) begin
            case ($urandom_range(0, 3))
                0: tps = 32'd1000;
                1: tps = 32'd10_000_000;
                2: tps = frjm_pkg::TPS_W'($urandom_range(100, 100_000));
                default: tps = $urandom;
            endcase
            ra = frjm_pkg::RATE_W'($urandom_range(20, 240) * 256 + $urandom_range(0, 255));
            rb = $urandom_range(0, 3) == 0 ? ra
                                           : frjm_pkg::RATE_W'($urandom_range(20, 240) * 256);
            write_all($urandom_range(0, 7) != 0, tps,
                      frjm_pkg::LIM_W'($urandom_range(0, 8000)), ra, rb);
            ts_now = frjm_pkg::TS_W'({$urandom_range(0, 255), $urandom});
            frame_stream(35, $urandom_range(0, 1) ? ra : rb);
            wait_idle();
        end
    endtask

    // Result sink stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            out_if.ready <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Compare each delivered result with the oldest expectation
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.kind, out_if.measured_rate, out_if.period_ticks, out_if.chosen_rate,
                    out_if.jitter_hit, out_if.entry_valid, out_if.last};
            if (expected_results.size() == 0) begin
                failed = 1'b1;
                $display("%0t: unexpected result %p", $realtime, got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    failed = 1'b1;
                    $display("%0t: expected %p actual %p", $realtime, want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.action = frjm_pkg::ACT_FRAME;
        in_if.timestamp = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = frjm_pkg::CFG_JITTER_ENABLE;
        cfg_if.data = '0;
        out_if.ready = 1'b1;
        en_q = 1'b1;
        tps_q = frjm_pkg::TPS_RESET;
        lim_q = frjm_pkg::LIMIT_RESET;
        rate_a_q = frjm_pkg::RATE_A_RESET;
        rate_b_q = frjm_pkg::RATE_B_RESET;
        frames_q = '0;
        win_start_q = '0;
        prev_stamp_q = '0;
        have_prev_q = 1'b0;
        rate_now_q = '0;
        ts_now = '0;
        for (int i = 0; i < DEPTH; i++) begin
            log_live_q[i] = 1'b0;
            log_stamp_q[i] = '0;
            log_per_q[i] = '0;
            log_rate_q[i] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_edges();
        test_log_expiry();
        test_random_phases(4);
        quiet = 1'b1;
        test_random_phases(1);

        if (failed || expected_results.size() != 0) begin
            $display("Mismatches found");
        end else begin
            $display("No mismatches found");
        end
        $finish;
    end
endmodule
